// ===== design/slcd_pkg.sv =====
// slcd_pkg: shared types and constants for the sync/length/checksum deframer
// no dependencies; compiled first

package slcd_pkg;

	localparam logic [7:0]  SYNC_FIRST    = 8'hA5;
	localparam logic [7:0]  SYNC_SECOND   = 8'h5A;
	localparam logic [16:0] MIN_TOTAL     = 17'd6;
	localparam logic [16:0] MAX_LEN_RESET = 17'd1024;
	localparam logic [15:0] HEADER_SUM    = 16'h00FF;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_SYNC = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_GOOD     = 2'd1,
		ST_CSUM_ERR = 2'd2,
		ST_LEN_ERR  = 2'd3
	} status_t;

	// one queued result; pair marks the header entry that expands to two items
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [16:0] position;
		logic [16:0] frame_size;
		logic        last;
		status_t     status;
		logic        pair;
	} entry_t;

endpackage

// ===== design/slcd_if.sv =====
// slcd_byte_if and slcd_frame_if: valid/ready channels of the deframer
// no dependencies

interface slcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;

	modport source (output valid, output data_in, input ready);
	modport sink   (input valid, input data_in, output ready);
endinterface

interface slcd_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [16:0] position;
	logic [16:0] frame_size;
	logic        last;
	logic [1:0]  status;

	modport source (output valid, output data_byte, output position, output frame_size,
		output last, output status, input ready);
	modport sink   (input valid, input data_byte, input position, input frame_size,
		input last, input status, output ready);
endinterface

// ===== design/slcd_front.sv =====
// slcd_front: accepts received bytes, tracks header/length/checksum, pushes results
// depends on slcd_pkg and slcd_byte_if

module slcd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [16:0]       cfg_wr_data,
	slcd_byte_if.sink         byte_ch,
	output logic              push_valid,
	input  logic              push_ready,
	output slcd_pkg::entry_t  push_entry
);
	import slcd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [16:0] max_len_q;
	logic [16:0] count_q, count_d;
	logic [16:0] total_q, total_d;
	logic [7:0]  len_low_q, len_low_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  chk_low_q, chk_low_d;

	logic        fire;
	logic        emit;
	logic [7:0]  b;
	logic [16:0] total_new;
	logic [17:0] p_plus2;
	logic [15:0] sum_add;

	assign b       = byte_ch.data_in;
	assign fire    = byte_ch.valid && push_ready;
	assign byte_ch.ready = push_ready;
	assign push_valid    = fire && emit;

	assign total_new = {1'b0, b, len_low_q} + 17'd2;
	assign p_plus2   = {1'b0, count_q} + 18'd2;
	assign sum_add   = sum_q + {8'd0, b};

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		total_d   = total_q;
		len_low_d = len_low_q;
		sum_d     = sum_q;
		chk_low_d = chk_low_q;
		emit      = 1'b0;
		push_entry.data_byte  = b;
		push_entry.position   = count_q;
		push_entry.frame_size = total_q;
		push_entry.last       = 1'b0;
		push_entry.status     = ST_BUSY;
		push_entry.pair       = 1'b0;
		case (phase_q)
			PH_SYNC: begin
				if (b == SYNC_SECOND) begin
					emit    = 1'b1;
					push_entry.position   = 17'd1;
					push_entry.frame_size = '0;
					push_entry.pair       = 1'b1;
					phase_d = PH_BODY;
					count_d = 17'd2;
					sum_d   = HEADER_SUM;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				emit = 1'b1;
				if (count_q < 17'd4) begin
					if (count_q == 17'd3)
						len_low_d = b;
					sum_d   = sum_add;
					push_entry.frame_size = '0;
					count_d = count_q + 17'd1;
				end else if (count_q == 17'd4) begin
					push_entry.frame_size = total_new;
					if (total_new < MIN_TOTAL || total_new > max_len_q) begin
						push_entry.last   = 1'b1;
						push_entry.status = ST_LEN_ERR;
						phase_d = PH_HUNT;
					end else begin
						total_d = total_new;
						if (total_new > MIN_TOTAL)
							sum_d = sum_add;
						else
							chk_low_d = b;
						count_d = 17'd5;
					end
				end else if (p_plus2 < {1'b0, total_q}) begin
					sum_d   = sum_add;
					count_d = count_q + 17'd1;
				end else if (p_plus2 == {1'b0, total_q}) begin
					chk_low_d = b;
					count_d   = count_q + 17'd1;
				end else begin
					push_entry.last   = 1'b1;
					push_entry.status = ({b, chk_low_q} == sum_q) ? ST_GOOD : ST_CSUM_ERR;
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = (b == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			if (fire)
				phase_q <= phase_d;
			if (cfg_wr_en)
				max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			count_q   <= count_d;
			total_q   <= total_d;
			len_low_q <= len_low_d;
			sum_q     <= sum_d;
			chk_low_q <= chk_low_d;
		end
	end

endmodule

// ===== design/slcd_queue.sv =====
// slcd_queue: short fifo of result entries between front and back
// depends on slcd_pkg

module slcd_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  slcd_pkg::entry_t  push_entry,
	output logic              pop_valid,
	input  logic              pop_ready,
	output slcd_pkg::entry_t  pop_entry
);
	import slcd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ===== design/slcd_back.sv =====
// slcd_back: drains the queue into the output register, expands header entries
// depends on slcd_pkg and slcd_frame_if

module slcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  slcd_pkg::entry_t  pop_entry,
	slcd_frame_if.source      frame_ch
);
	import slcd_pkg::*;

	logic        out_valid_q;
	logic        second_q;
	logic [7:0]  data_q;
	logic [16:0] pos_q;
	logic [16:0] size_q;
	logic        last_q;
	status_t     status_q;
	logic        load;

	assign load      = !out_valid_q || frame_ch.ready;
	assign pop_ready = load && !second_q;

	assign frame_ch.valid      = out_valid_q;
	assign frame_ch.data_byte  = data_q;
	assign frame_ch.position   = pos_q;
	assign frame_ch.frame_size = size_q;
	assign frame_ch.last       = last_q;
	assign frame_ch.status     = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= second_q || pop_valid;
			if (second_q)
				second_q <= 1'b0;
			else if (pop_valid && pop_entry.pair)
				second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				data_q   <= SYNC_SECOND;
				pos_q    <= 17'd1;
				size_q   <= '0;
				last_q   <= 1'b0;
				status_q <= ST_BUSY;
			end else if (pop_valid && pop_entry.pair) begin
				data_q   <= SYNC_FIRST;
				pos_q    <= '0;
				size_q   <= '0;
				last_q   <= 1'b0;
				status_q <= ST_BUSY;
			end else if (pop_valid) begin
				data_q   <= pop_entry.data_byte;
				pos_q    <= pop_entry.position;
				size_q   <= pop_entry.frame_size;
				last_q   <= pop_entry.last;
				status_q <= pop_entry.status;
			end
		end
	end

endmodule

// ===== design/sync_length_checksum_deframer_core.sv =====
// sync_length_checksum_deframer_core: top level, front parser, result queue, output stage
// a result item is written into the queue when its byte is accepted, then registered in
// the output stage; the second header item is made there once the first has been taken
// throughput: one byte per cycle, stalled by byte_ch.ready while the result queue is full
// reset: arst_n returns to hunting, empties the queue and output stage, max_frame_len = 1024

module sync_length_checksum_deframer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [16:0]   cfg_wr_data,
	slcd_byte_if.sink     byte_ch,
	slcd_frame_if.source  frame_ch
);
	import slcd_pkg::*;

	logic   push_valid, push_ready;
	logic   pop_valid, pop_ready;
	entry_t push_entry, pop_entry;

	slcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.byte_ch     (byte_ch),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	slcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	slcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.frame_ch  (frame_ch)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_valid && !push_ready))
		else $error("result pushed into a full queue");

	a_status_implies_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ch.valid && (frame_ch.status != ST_BUSY) |-> frame_ch.last)
		else $error("final status without last");

	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ch.valid && (frame_ch.position == 17'd0) |->
		(frame_ch.data_byte == SYNC_FIRST) && !frame_ch.last && (frame_ch.frame_size == 17'd0))
		else $error("position zero item is not the first header byte");

	a_second_header_follows: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ch.valid && frame_ch.ready && (frame_ch.position == 17'd0) |=>
		frame_ch.valid && (frame_ch.position == 17'd1) && (frame_ch.data_byte == SYNC_SECOND))
		else $error("second header item did not follow the first");

endmodule
